>>> sv/kea_pkg.sv
`default_nettype none

package kea_pkg;

  // Key table size and derived address width
  localparam int NUM_KEYS = 256;
  localparam int KEY_AW   = $clog2(NUM_KEYS);

  // Result queue size and derived widths
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Register reset values
  localparam logic [15:0] DELAY_RESET    = 16'd400;
  localparam logic [9:0]  INTERVAL_RESET = 10'd25;
  localparam logic        ENABLE_RESET   = 1'b1;

  // Register indexes on the write port
  localparam logic [1:0] REG_DELAY    = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_ENABLE   = 2'd2;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_REPEAT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [15:0] delay;
    logic [9:0]  interval;
    logic        enable;
  } cfg_t;

  // Per-key entry held in the key table
  typedef struct packed {
    logic        down;
    logic [15:0] hold;
    logic [9:0]  phase;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef struct packed {
    kind_t      kind;
    logic [7:0] key;
  } evt_t;

  // Status from the update pipeline to the top level
  typedef struct packed {
    logic clearing;
    logic busy;
  } pipe_stat_t;

endpackage

`default_nettype wire

>>> sv/kea_ram.sv
`default_nettype none

module kea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read; a read of the address being written gets old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/kea_fifo.sv
`default_nettype none

module kea_fifo (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire kea_pkg::evt_t                   push_evt,
  input  wire logic                            pop,
  output logic                                 nonempty,
  output kea_pkg::evt_t                        head_evt,
  output logic      [kea_pkg::FIFO_CW-1:0]     count
);

  import kea_pkg::*;

  evt_t               slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               do_pop;

  assign nonempty = (count != '0);
  assign head_evt = slots[rd_ptr];
  assign do_pop   = pop && nonempty;

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_evt;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (push && !do_pop) begin
        count <= count + FIFO_CW'(1);
      end else if (do_pop && !push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/kea_pipe.sv
`default_nettype none

module kea_pipe (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kea_pkg::cfg_t     cfg,
  input  wire logic              accept,
  input  wire logic [7:0]        key_code,
  input  wire logic              key_down,
  output logic                   push,
  output kea_pkg::evt_t          push_evt,
  output kea_pkg::pipe_stat_t    stat
);

  import kea_pkg::*;

  // Clearing sweep
  logic              clearing;
  logic [KEY_AW-1:0] clr_addr;

  // Lookup stage
  logic              s1_valid;
  logic [7:0]        s1_key;
  logic              s1_down;
  logic              s1_inrange;
  logic [KEY_AW-1:0] s1_addr;

  // Last item write, for a read that overlapped it
  logic              fwd_valid;
  logic [KEY_AW-1:0] fwd_addr;
  ent_t              fwd_data;

  // Table ports
  logic              ram_we;
  logic [KEY_AW-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  // Update logic
  ent_t              cur;
  ent_t              nxt;
  logic [15:0]       hold_inc;
  logic [10:0]       phase_inc;
  logic [15:0]       hold_new;
  logic [9:0]        phase_new;
  logic              upd_we;

  assign s1_addr = KEY_AW'(s1_key);

  kea_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_KEYS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(KEY_AW'(key_code)),
    .rdata(ram_rdata)
  );

  // Sweep the table once after reset to clear the down bits
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + KEY_AW'(1);
      if (clr_addr == KEY_AW'(NUM_KEYS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Capture the accepted sample alongside its table read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_key     <= key_code;
      s1_down    <= key_down;
      s1_inrange <= (32'(key_code) < NUM_KEYS);
    end
  end

  // Pick the freshest entry and apply the edge and repeat rules
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur = fwd_data;
    end else begin
      cur = ent_t'(ram_rdata);
    end
    // The increment is only taken while hold is below the delay, so it never wraps
    hold_inc  = cur.hold + 16'd1;
    phase_inc = {1'b0, cur.phase} + 11'd1;
    hold_new  = (cur.hold >= cfg.delay) ? cfg.delay : hold_inc;
    phase_new = (phase_inc >= {1'b0, cfg.interval}) ? 10'd0 : phase_inc[9:0];

    nxt           = cur;
    nxt.down      = s1_down;
    push          = 1'b0;
    push_evt.kind = KIND_PRESS;
    push_evt.key  = s1_key;
    upd_we        = s1_valid && s1_inrange;

    priority if (s1_down && !cur.down) begin
      nxt.hold  = '0;
      nxt.phase = '0;
      push      = upd_we;
    end else if (!s1_down && cur.down) begin
      push          = upd_we;
      push_evt.kind = KIND_RELEASE;
    end else if (s1_down && cfg.enable) begin
      nxt.hold      = hold_new;
      nxt.phase     = phase_new;
      push          = upd_we && (hold_new >= cfg.delay) && (phase_new == '0);
      push_evt.kind = KIND_REPEAT;
    end
  end

  // Write back, sweep writes first
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_addr;
      ram_wdata = ENT_W'(nxt);
    end
  end

  // Hold the last item write for the read issued in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (upd_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= nxt;
    end
  end

  assign stat.clearing = clearing;
  assign stat.busy     = s1_valid;

endmodule

`default_nettype wire

>>> sv/key_edge_autorepeat.sv
// Channel  | Signals                 | Contents (lowest bit first)
// ---------+-------------------------+-----------------------------------------
// s_       | tvalid tready tdata     | tdata[7:0] key_code, [8] key_down, rest 0
// m_       | tvalid tready tdata tuser | tdata[7:0] event_key; tuser[1:0] kind
// cfg_     | we addr wdata           | 0 delay, 1 interval, 2 autorepeat enable
//
// One sample is taken every cycle while s_tready is high; an event it raises passes the
// lookup stage into the result queue. The per-key state lives in one table RAM read in
// the accept cycle and written back in the next; the latest write is forwarded to a read
// of the same key. After reset all NUM_KEYS (256) entries are swept with s_tready low.
// Results wait in a 4-beat queue; s_tready falls when queued plus in-flight beats reach 4.
`default_nettype none

module key_edge_autorepeat (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] key_code, [8] key_down, [15:9] zero
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [7:0] event_key
  output logic      [1:0]  m_tuser,   // [1:0] event_kind
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  import kea_pkg::*;

  cfg_t               cfg;
  logic               accept;
  logic               push;
  evt_t               push_evt;
  pipe_stat_t         stat;
  evt_t               head_evt;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW:0]   occupied;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delay    <= DELAY_RESET;
      cfg.interval <= INTERVAL_RESET;
      cfg.enable   <= ENABLE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DELAY:    cfg.delay    <= cfg_wdata;
        REG_INTERVAL: cfg.interval <= cfg_wdata[9:0];
        REG_ENABLE:   cfg.enable   <= cfg_wdata[0];
        default:      ;
      endcase
    end
  end

  // Take a sample only while the queue has room for everything in flight
  assign occupied = {1'b0, count} + (FIFO_CW + 1)'(stat.busy);
  assign s_tready = !stat.clearing && (occupied < (FIFO_CW + 1)'(FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;

  kea_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .key_code(s_tdata[7:0]),
    .key_down(s_tdata[8]),
    .push    (push),
    .push_evt(push_evt),
    .stat    (stat)
  );

  kea_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_evt(push_evt),
    .pop     (m_tready),
    .nonempty(m_tvalid),
    .head_evt(head_evt),
    .count   (count)
  );

  assign m_tdata = head_evt.key;
  assign m_tuser = head_evt.kind;

endmodule

`default_nettype wire

>>> sv/kea_checker.sv
`default_nettype none

module kea_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic [1:0]  m_tuser
);

  // The table sweep blocks input right after reset
  a_sweep_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during table sweep");

  // A rising m_tvalid follows an accepted sample through the lookup stage and the queue
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a sample");

  // Event kinds stay within press, release and repeat
  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'd3))
    else $error("bad event kind");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed under stall");

endmodule

bind key_edge_autorepeat kea_checker u_kea_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
